FILE: hdl/smps_pkg.sv
package smps_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int OP_W     = 2;
    localparam int VALUE_W  = 32;
    localparam int RANK_W   = 7;
    localparam int TOTAL_W  = 38;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    localparam int S_DATA_W = ((VALUE_W + RANK_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((TOTAL_W + COUNT_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT    = 2'd0,
        OP_DELETE    = 2'd1,
        OP_SUM_BELOW = 2'd2,
        OP_SUM_RANK  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_NOT_FOUND = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

endpackage

FILE: hdl/smps_ram.sv
module smps_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hdl/sorted_multiset_prefix_sum.sv
// Sorted multiset of up to CAPACITY signed 32-bit values kept in ascending order in a
// one-write, one-read memory. Each request (insert, delete one copy, sum of values below
// a key, sum of the k smallest) gives one result with the sum, the element count after
// the request and a status. The stored entries are walked one per cycle through the
// single read port, with one shared compare and one shared 38-bit adder working on the
// entry just read; an insert stops as soon as its slot is found, and an insert into a
// full store skips the walk and goes straight to its result. The input is not ready
// while a request is in work; a finished result sits in an output register, so the
// next request is taken while the previous result waits.
module sorted_multiset_prefix_sum (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // value [31:0], rank [38:32], zero pad
    input  logic [smps_pkg::S_DATA_W-1:0] s_axis_tdata,
    // operation [1:0]
    input  logic [smps_pkg::OP_W-1:0]     s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // total [37:0], count [44:38], zero pad
    output logic [smps_pkg::M_DATA_W-1:0] m_axis_tdata,
    // status [1:0]
    output logic [smps_pkg::STATUS_W-1:0] m_axis_tuser
);

    import smps_pkg::*;

    localparam int CMP_W = (ADDR_W > RANK_W) ? ADDR_W : RANK_W;

    state_t                     state_reg, state_next;
    op_t                        op_reg, op_next;
    logic signed [VALUE_W-1:0]  val_reg, val_next;
    logic [RANK_W-1:0]          rank_reg, rank_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [ADDR_W-1:0]          rd_addr_reg, rd_addr_next;
    logic [CNT_W-1:0]           left_reg, left_next;
    logic                       pipe_vld_reg, pipe_vld_next;
    logic [ADDR_W-1:0]          pipe_idx_reg, pipe_idx_next;
    logic                       found_reg, found_next;
    logic                       placed_reg, placed_next;
    logic signed [TOTAL_W-1:0]  acc_reg, acc_next;
    status_t                    status_reg, status_next;

    logic                       out_valid_reg, out_valid_next;
    logic [TOTAL_W-1:0]         out_total_reg, out_total_next;
    logic [COUNT_W-1:0]         out_count_reg, out_count_next;
    status_t                    out_status_reg, out_status_next;

    logic                       accept;
    logic                       finish;
    logic                       slot_free;
    logic                       rd_en;
    logic [VALUE_W-1:0]         rd_data;
    logic                       wr_en;
    logic [ADDR_W-1:0]          wr_addr;
    logic [VALUE_W-1:0]         wr_data;
    logic                       data_lt;
    logic                       data_eq;
    logic                       add_en;
    logic signed [TOTAL_W-1:0]  add_sum;
    logic                       place_now;

    smps_ram #(
        .DEPTH(CAPACITY),
        .WIDTH(VALUE_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr_reg),
        .rd_data (rd_data)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign finish        = (state_reg == S_SCAN) && (left_reg == '0) && !pipe_vld_reg;
    assign slot_free     = !out_valid_reg || m_axis_tready;

    // shared compare and adder
    assign data_lt = $signed(rd_data) < val_reg;
    assign data_eq = $signed(rd_data) == val_reg;
    assign add_sum = acc_reg + TOTAL_W'($signed(rd_data));

    assign place_now = pipe_vld_reg && (op_reg == OP_INSERT) && (data_lt || data_eq);
    assign rd_en     = (state_reg == S_SCAN) && (left_reg != '0) && !place_now;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if ((op_t'(s_axis_tuser) == OP_INSERT) && (cnt_reg >= CNT_W'(CAPACITY)))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (finish)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        op_next         = op_reg;
        val_next        = val_reg;
        rank_next       = rank_reg;
        cnt_next        = cnt_reg;
        rd_addr_next    = rd_addr_reg;
        left_next       = left_reg;
        pipe_vld_next   = rd_en;
        pipe_idx_next   = rd_addr_reg;
        found_next      = found_reg;
        placed_next     = placed_reg;
        acc_next        = acc_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_total_next  = out_total_reg;
        out_count_next  = out_count_reg;
        out_status_next = out_status_reg;
        wr_en           = 1'b0;
        wr_addr         = pipe_idx_reg;
        wr_data         = rd_data;
        add_en          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = op_t'(s_axis_tuser);
                    val_next    = $signed(s_axis_tdata[VALUE_W-1:0]);
                    rank_next   = s_axis_tdata[VALUE_W +: RANK_W];
                    left_next   = cnt_reg;
                    found_next  = 1'b0;
                    placed_next = 1'b0;
                    acc_next    = '0;
                    status_next = STATUS_OK;
                    if (op_t'(s_axis_tuser) == OP_INSERT)
                    begin
                        rd_addr_next = cnt_reg[ADDR_W-1:0] - ADDR_W'(1);
                        if (cnt_reg >= CNT_W'(CAPACITY))
                        begin
                            status_next = STATUS_FULL;
                            left_next   = '0;
                        end
                    end
                    else
                    begin
                        rd_addr_next = '0;
                    end
                end
            end
            S_SCAN:
            begin
                if (rd_en)
                begin
                    left_next = left_reg - CNT_W'(1);
                    if (op_reg == OP_INSERT)
                    begin
                        rd_addr_next = rd_addr_reg - ADDR_W'(1);
                    end
                    else
                    begin
                        rd_addr_next = rd_addr_reg + ADDR_W'(1);
                    end
                end

                if (pipe_vld_reg)
                begin
                    case (op_reg)
                        OP_INSERT:
                        begin
                            wr_en   = 1'b1;
                            wr_addr = pipe_idx_reg + ADDR_W'(1);
                            if (place_now)
                            begin
                                wr_data       = val_reg;
                                placed_next   = 1'b1;
                                left_next     = '0;
                                pipe_vld_next = 1'b0;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (found_reg)
                            begin
                                wr_en   = 1'b1;
                                wr_addr = pipe_idx_reg - ADDR_W'(1);
                            end
                            else if (data_eq)
                            begin
                                found_next = 1'b1;
                            end
                        end
                        OP_SUM_BELOW:
                        begin
                            add_en = data_lt;
                        end
                        OP_SUM_RANK:
                        begin
                            add_en = CMP_W'(pipe_idx_reg) < CMP_W'(rank_reg);
                        end
                        default:
                        begin
                            add_en = 1'b0;
                        end
                    endcase
                end

                if (add_en)
                begin
                    acc_next = add_sum;
                end

                if (finish)
                begin
                    if (op_reg == OP_INSERT)
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                        if (!placed_reg)
                        begin
                            wr_en   = 1'b1;
                            wr_addr = '0;
                            wr_data = val_reg;
                        end
                    end
                    else if (op_reg == OP_DELETE)
                    begin
                        if (found_reg)
                        begin
                            cnt_next = cnt_reg - CNT_W'(1);
                        end
                        else
                        begin
                            status_next = STATUS_NOT_FOUND;
                        end
                    end
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_total_next  = acc_reg;
                    out_count_next  = COUNT_W'(cnt_reg);
                    out_status_next = status_reg;
                end
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            left_reg      <= '0;
            pipe_vld_reg  <= 1'b0;
            found_reg     <= 1'b0;
            placed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            left_reg      <= left_next;
            pipe_vld_reg  <= pipe_vld_next;
            found_reg     <= found_next;
            placed_reg    <= placed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        val_reg        <= val_next;
        rank_reg       <= rank_next;
        rd_addr_reg    <= rd_addr_next;
        pipe_idx_reg   <= pipe_idx_next;
        acc_reg        <= acc_next;
        status_reg     <= status_next;
        out_total_reg  <= out_total_next;
        out_count_reg  <= out_count_next;
        out_status_reg <= out_status_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(M_DATA_W - TOTAL_W - COUNT_W){1'b0}}, out_count_reg, out_total_reg};
    assign m_axis_tuser  = out_status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("stored count above capacity");

    a_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == S_SCAN))
        else $error("memory write outside scan");

    a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pipe_vld_reg |-> (state_reg == S_SCAN))
        else $error("read data pending outside scan");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DONE) && slot_free) |=> m_axis_tvalid)
        else $error("finished request not presented");

    a_full_only_insert: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DONE) && (status_reg == STATUS_FULL)) |-> (op_reg == OP_INSERT))
        else $error("full status on a non-insert request");

endmodule

FILE: bench/sorted_multiset_prefix_sum_tb.sv
module sorted_multiset_prefix_sum_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import smps_pkg::*;

    localparam int REQUEST_TOTAL = 1475;
    localparam int QUIET_LIMIT   = 5000;
    localparam int DRAIN_CYCLES  = 100;

    typedef struct {
        op_t                        op;
        logic signed [VALUE_W-1:0]  value;
        logic [RANK_W-1:0]          rank;
    } request_t;

    typedef struct {
        logic [TOTAL_W-1:0]  total;
        logic [COUNT_W-1:0]  count;
        status_t             status;
    } outcome_t;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [OP_W-1:0]      s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_axis_tdata;
    logic [STATUS_W-1:0]  m_axis_tuser;

    request_t  request_queue[$];
    outcome_t  expected_outcomes[$];
    request_t  in_flight;

    // stored values as the next request will see them
    logic signed [VALUE_W-1:0]  multiset_vals[CAPACITY];
    int                         multiset_size = 0;

    // contents as planned while building the request list
    logic signed [VALUE_W-1:0]  planned_vals[$];

    int   requests_sent = 0;
    int   results_seen  = 0;
    int   mismatches    = 0;
    int   full_seen     = 0;
    int   absent_seen   = 0;
    int   peak_size     = 0;
    int   send_gap      = 0;
    int   hold_left     = 0;
    int   quiet_cycles  = 0;
    logic calm;

    assign calm = (requests_sent >= 500) && (requests_sent < 750);

    sorted_multiset_prefix_sum u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic outcome_t apply_to_multiset(request_t req);
        outcome_t                   res;
        int                         pos;
        int                         limit;
        logic signed [TOTAL_W-1:0]  acc;
        logic signed [VALUE_W-1:0]  v;
        res.status = STATUS_OK;
        acc = '0;
        pos = 0;
        case (req.op)
            OP_INSERT:
            begin
                if (multiset_size >= CAPACITY)
                begin
                    res.status = STATUS_FULL;
                    full_seen++;
                end
                else
                begin
                    while (pos < multiset_size && multiset_vals[pos] < req.value)
                        pos++;
                    for (int i = multiset_size; i > pos; i--)
                        multiset_vals[i] = multiset_vals[i-1];
                    multiset_vals[pos] = req.value;
                    multiset_size++;
                end
            end
            OP_DELETE:
            begin
                while (pos < multiset_size && multiset_vals[pos] != req.value)
                    pos++;
                if (pos >= multiset_size)
                begin
                    res.status = STATUS_NOT_FOUND;
                    absent_seen++;
                end
                else
                begin
                    for (int i = pos; i + 1 < multiset_size; i++)
                        multiset_vals[i] = multiset_vals[i+1];
                    multiset_size--;
                end
            end
            OP_SUM_BELOW:
            begin
                for (int i = 0; i < multiset_size && multiset_vals[i] < req.value; i++)
                begin
                    v = multiset_vals[i];
                    acc = acc + {{(TOTAL_W-VALUE_W){v[VALUE_W-1]}}, v};
                end
            end
            default:
            begin
                limit = (int'(req.rank) > multiset_size) ? multiset_size : int'(req.rank);
                for (int i = 0; i < limit; i++)
                begin
                    v = multiset_vals[i];
                    acc = acc + {{(TOTAL_W-VALUE_W){v[VALUE_W-1]}}, v};
                end
            end
        endcase
        if (multiset_size > peak_size)
            peak_size = multiset_size;
        res.total = acc;
        res.count = COUNT_W'(multiset_size);
        return res;
    endfunction

    task automatic add_request(op_t op, logic signed [VALUE_W-1:0] value,
                               logic [RANK_W-1:0] rank);
        request_t req;
        int       idx;
        req.op = op;
        req.value = value;
        req.rank = rank;
        idx = -1;
        request_queue.insert(request_queue.size(), req);
        if (op == OP_INSERT && planned_vals.size() < CAPACITY)
            planned_vals.insert(planned_vals.size(), value);
        else if (op == OP_DELETE)
        begin
            for (int i = 0; i < planned_vals.size(); i++)
                if (idx < 0 && planned_vals[i] == value)
                    idx = i;
            if (idx >= 0)
                planned_vals.delete(idx);
        end
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return int'($urandom_range(0, 16)) - 8;
            2:
            begin
                case ($urandom_range(0, 5))
                    0: return 32'h8000_0000;
                    1: return 32'h8000_0001;
                    2: return 32'h7fff_ffff;
                    3: return 32'h7fff_fffe;
                    4: return 32'h0000_0000;
                    default: return 32'hffff_ffff;
                endcase
            end
            default:
            begin
                if (planned_vals.size() != 0)
                    return planned_vals[$urandom_range(0, planned_vals.size() - 1)];
                return $urandom;
            end
        endcase
    endfunction

    // request list, then end of run
    initial
    begin
        bit                         filling;
        int                         full_hits;
        int                         roll;
        op_t                        op;
        logic signed [VALUE_W-1:0]  v;
        logic [RANK_W-1:0]          k;

        filling = 1'b1;
        full_hits = 0;

        // empty store
        add_request(OP_SUM_BELOW, 32'h0000_0000, 7'd0);
        add_request(OP_SUM_RANK,  32'h0000_0000, 7'd64);
        add_request(OP_DELETE,    32'h0000_0005, 7'd0);
        // extremes and a duplicate
        add_request(OP_INSERT,    32'h7fff_ffff, 7'd0);
        add_request(OP_INSERT,    32'h8000_0000, 7'd0);
        add_request(OP_INSERT,    32'h0000_0000, 7'd0);
        add_request(OP_INSERT,    32'hffff_ffff, 7'd0);
        add_request(OP_INSERT,    32'hffff_ffff, 7'd0);
        add_request(OP_INSERT,    32'h0000_0007, 7'd0);
        // key bounds
        add_request(OP_SUM_BELOW, 32'h8000_0000, 7'd0);
        add_request(OP_SUM_BELOW, 32'h7fff_ffff, 7'd0);
        add_request(OP_SUM_BELOW, 32'h0000_0000, 7'd0);
        // rank zero, inside, above count
        add_request(OP_SUM_RANK,  32'h0000_0000, 7'd0);
        add_request(OP_SUM_RANK,  32'h0000_0000, 7'd3);
        add_request(OP_SUM_RANK,  32'hffff_ffff, 7'd127);
        add_request(OP_SUM_RANK,  32'h0000_0000, 7'd64);
        // one copy of a duplicate, then an absent value
        add_request(OP_DELETE,    32'hffff_ffff, 7'd0);
        add_request(OP_DELETE,    32'h0000_3039, 7'd0);
        add_request(OP_SUM_RANK,  32'h0000_0000, 7'd6);
        add_request(OP_DELETE,    32'h8000_0000, 7'd0);
        add_request(OP_DELETE,    32'h7fff_ffff, 7'd0);
        add_request(OP_SUM_BELOW, 32'hffff_ffff, 7'd127);
        add_request(OP_INSERT,    32'h5555_5555, 7'h2a);
        add_request(OP_INSERT,    32'haaaa_aaaa, 7'h55);
        add_request(OP_SUM_RANK,  32'h1234_5678, 7'h55);

        // fill to full, push against the limit, then drain to empty
        while (request_queue.size() < REQUEST_TOTAL)
        begin
            roll = $urandom_range(0, 99);
            k = ($urandom_range(0, 9) < 7) ? RANK_W'($urandom_range(0, CAPACITY))
                                           : RANK_W'($urandom);
            v = pick_value();
            if (filling)
                op = (roll < 70) ? OP_INSERT : (roll < 78) ? OP_DELETE :
                     (roll < 89) ? OP_SUM_BELOW : OP_SUM_RANK;
            else
            begin
                op = (roll < 62) ? OP_DELETE : (roll < 72) ? OP_INSERT :
                     (roll < 86) ? OP_SUM_BELOW : OP_SUM_RANK;
                if (op == OP_DELETE && planned_vals.size() != 0 && $urandom_range(0, 9) != 0)
                    v = planned_vals[$urandom_range(0, planned_vals.size() - 1)];
            end
            add_request(op, v, k);
            if (filling && planned_vals.size() == CAPACITY)
            begin
                full_hits++;
                if (full_hits >= 4)
                begin
                    filling = 1'b0;
                    full_hits = 0;
                end
            end
            if (planned_vals.size() == 0)
                filling = 1'b1;
        end

        wait (rst_n);
        while (requests_sent < REQUEST_TOTAL || expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run: %0d requests, %0d results checked, %0d mismatches, peak store %0d",
                 requests_sent, results_seen, mismatches, peak_size);
        $display("run: %0d inserts into a full store, %0d deletes of absent values",
                 full_seen, absent_seen);
        if (mismatches == 0 && expected_outcomes.size() == 0)
            $display("sorted_multiset_prefix_sum_tb OK");
        else
            $display("sorted_multiset_prefix_sum_tb NOT OK");
        $finish;
    end

    // request driver
    always @(posedge clk)
    begin
        request_t next_req;
        outcome_t predicted;
        bit       take;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predicted = apply_to_multiset(in_flight);
                expected_outcomes.insert(expected_outcomes.size(), predicted);
                requests_sent <= requests_sent + 1;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                take = 1'b0;
                if (send_gap > 0)
                    send_gap--;
                else if (request_queue.size() != 0)
                begin
                    if (calm || $urandom_range(0, 99) >= 25)
                        take = 1'b1;
                    else if ($urandom_range(0, 4) == 0)
                        send_gap = $urandom_range(1, 8);
                end
                if (take)
                begin
                    next_req = request_queue.pop_front();
                    in_flight = next_req;
                    s_axis_tdata <= S_DATA_W'({next_req.rank, next_req.value});
                    s_axis_tuser <= next_req.op;
                    s_axis_tvalid <= 1'b1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result monitor and checker
    always @(posedge clk)
    begin
        outcome_t seen;
        outcome_t want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen.total = m_axis_tdata[TOTAL_W-1:0];
                seen.count = m_axis_tdata[TOTAL_W +: COUNT_W];
                seen.status = status_t'(m_axis_tuser);
                results_seen <= results_seen + 1;
                if (expected_outcomes.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%t: unexpected result: total=%0d count=%0d status=%0d",
                                 $realtime, $signed(seen.total), seen.count, seen.status);
                    mismatches++;
                end
                else
                begin
                    want = expected_outcomes.pop_front();
                    if (seen.total !== want.total || seen.count !== want.count ||
                        seen.status !== want.status)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("%t: mismatch: expected total=%0d count=%0d status=%0d",
                                     $realtime, $signed(want.total), want.count, want.status);
                            $display("%t: mismatch: got      total=%0d count=%0d status=%0d",
                                     $realtime, $signed(seen.total), seen.count, seen.status);
                        end
                        mismatches++;
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (calm || $urandom_range(0, 99) >= 25)
                m_axis_tready <= 1'b1;
            else
            begin
                m_axis_tready <= 1'b0;
                if ($urandom_range(0, 4) == 0)
                    hold_left = $urandom_range(1, 8);
            end
        end
    end

    // no progress on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no request or result moved for %0d cycles", QUIET_LIMIT);
                $display("sorted_multiset_prefix_sum_tb NOT OK");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
